>>> rtl/core/srs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants of the segment range splitter
// Request and result formats, queue entry and sizing constants.
// ---------------------------------------------------------------------------
package srs_pkg;

	localparam int MAX_BUFFERS = 16;
	localparam int OFFSET_BITS = 48;
	localparam int IDX_W       = $clog2(MAX_BUFFERS);
	localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);
	localparam int SUM_W       = OFFSET_BITS + 1;
	localparam int ADDR_W      = 64;
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SPLIT = 1'b1;

	// register word index
	localparam logic REG_BUFFERS_IN_USE = 1'b0;

	typedef struct packed {
		logic                   action;
		logic [3:0]             entry_index;
		logic [OFFSET_BITS-1:0] entry_length;
		logic [OFFSET_BITS-1:0] req_offset;
		logic [OFFSET_BITS-1:0] request_length;
		logic [ADDR_W-1:0]      source_address;
		logic                   opcode;
	} item_t;

	typedef struct packed {
		logic [3:0]             buffer_index;
		logic [OFFSET_BITS-1:0] buf_offset;
		logic [OFFSET_BITS-1:0] slice_length;
		logic [ADDR_W-1:0]      slice_source_address;
		logic                   slice_opcode;
		logic                   last;
	} result_t;

	// classified request as it sits in the queue
	typedef struct packed {
		logic                   is_split;
		logic [IDX_W-1:0]       index;
		logic [OFFSET_BITS-1:0] length;
		logic [SUM_W-1:0]       seg_start;
		logic [SUM_W-1:0]       seg_end;
		logic [ADDR_W-1:0]      src;
		logic                   opcode;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/srs_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_front: request intake
// Registers an accepted request, classifies it and computes the range end.
// ---------------------------------------------------------------------------
module srs_front import srs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire item_t   item,
	output logic         busy,
	input  wire q_stat_t q_stat,
	output logic         push,
	output cmd_t         cmd
);

	logic hold_valid_q;
	cmd_t hold_q;
	cmd_t next_cmd;
	logic accept;

	assign push   = hold_valid_q & ~q_stat.full;
	assign busy   = hold_valid_q & q_stat.full;
	assign accept = start & ~busy;
	assign cmd    = hold_q;

	always_comb begin
		next_cmd.is_split  = (item.action == ACT_SPLIT);
		next_cmd.index     = IDX_W'(item.entry_index);
		next_cmd.length    = item.entry_length;
		next_cmd.seg_start = {1'b0, item.req_offset};
		// one bit wider, cannot exceed the saturation cap
		next_cmd.seg_end   = {1'b0, item.req_offset} + {1'b0, item.request_length};
		next_cmd.src       = item.source_address;
		next_cmd.opcode    = item.opcode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= next_cmd;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/srs_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_fifo: request queue
// Short queue that decouples intake from the range walker.
// ---------------------------------------------------------------------------
module srs_fifo import srs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	input  wire logic pop,
	output cmd_t      rd_cmd,
	output q_stat_t   q_stat
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_wr        = push & ~q_stat.full;
	assign do_rd        = pop & ~q_stat.empty;
	assign rd_cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/srs_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srs_back: buffer table and range walker
// Steps through the buffers in use one per cycle and emits overlap slices.
// ---------------------------------------------------------------------------
module srs_back import srs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire q_stat_t          q_stat,
	input  wire logic [CNT_W-1:0] buffers_in_use,
	output logic                  pop,
	output result_t               result,
	output logic                  result_strobe
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_END} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SUM_W-1:0]       cur_q;
	cmd_t                   req_q;

	logic [OFFSET_BITS-1:0] len_tab_q [MAX_BUFFERS];

	logic [CNT_W-1:0]       n_eff;
	logic [SUM_W:0]         end_sum;
	logic [SUM_W-1:0]       buf_end;
	logic                   last_step;

	// stage 1: one buffer step
	logic                   valid_s1, end_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [SUM_W-1:0]       cur_s1, buf_end_s1, seg_start_s1, seg_end_s1;
	logic [ADDR_W-1:0]      src_s1;
	logic                   op_s1;

	// stage 2: overlap decided
	logic                   valid_s2, end_s2, hit_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [SUM_W-1:0]       cur_s2, ov_s_s2, ov_e_s2, delta_s2;
	logic [ADDR_W-1:0]      src_s2;
	logic                   op_s2;

	logic                   hit;
	logic                   cur_above;
	logic [SUM_W-1:0]       ov_s, ov_e, delta;
	logic [SUM_W-1:0]       off_diff, len_diff;

	result_t                rec;
	result_t                pend_q;
	result_t                pend_last;
	logic                   pend_valid_q;
	result_t                result_q;
	logic                   result_strobe_q;

	assign n_eff     = (buffers_in_use > CNT_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS)
	                                                          : buffers_in_use;
	assign pop       = (state_q == ST_IDLE) & ~q_stat.empty;
	assign last_step = (CNT_W'(idx_q) + CNT_W'(1)) == n_eff;

	// running end, saturating one bit above the offset width
	assign end_sum = {1'b0, cur_q} + {{(SUM_W+1-OFFSET_BITS){1'b0}}, len_tab_q[idx_q]};
	assign buf_end = end_sum[SUM_W] ? '1 : end_sum[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cur_q   <= '0;
			req_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && cmd.is_split) begin
						req_q   <= cmd;
						idx_q   <= '0;
						cur_q   <= '0;
						state_q <= (n_eff == '0) ? ST_END : ST_WALK;
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + IDX_W'(1);
					cur_q <= buf_end;
					if (last_step) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.is_split) begin
			len_tab_q[cmd.index] <= cmd.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			end_s1   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_WALK) || (state_q == ST_END);
			end_s1   <= (state_q == ST_END);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= idx_q;
		cur_s1       <= cur_q;
		buf_end_s1   <= buf_end;
		seg_start_s1 <= req_q.seg_start;
		seg_end_s1   <= req_q.seg_end;
		src_s1       <= req_q.src;
		op_s1        <= req_q.opcode;
	end

	// max(start,cur) < min(end,buf_end) as four independent compares
	assign hit = (seg_start_s1 < seg_end_s1) && (seg_start_s1 < buf_end_s1)
	          && (cur_s1 < seg_end_s1) && (cur_s1 < buf_end_s1);
	assign cur_above = cur_s1 > seg_start_s1;
	assign ov_s      = cur_above ? cur_s1 : seg_start_s1;
	assign ov_e      = (seg_end_s1 < buf_end_s1) ? seg_end_s1 : buf_end_s1;
	assign delta     = cur_above ? (cur_s1 - seg_start_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			end_s2   <= 1'b0;
			hit_s2   <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			end_s2   <= end_s1;
			hit_s2   <= hit;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2   <= idx_s1;
		cur_s2   <= cur_s1;
		ov_s_s2  <= ov_s;
		ov_e_s2  <= ov_e;
		delta_s2 <= delta;
		src_s2   <= src_s1;
		op_s2    <= op_s1;
	end

	assign off_diff = ov_s_s2 - cur_s2;
	assign len_diff = ov_e_s2 - ov_s_s2;

	always_comb begin
		rec.buffer_index         = 4'(idx_s2);
		rec.buf_offset           = off_diff[OFFSET_BITS-1:0];
		rec.slice_length         = len_diff[OFFSET_BITS-1:0];
		rec.slice_source_address = src_s2 + {{(ADDR_W-SUM_W){1'b0}}, delta_s2};
		rec.slice_opcode         = op_s2;
		rec.last                 = 1'b0;
	end

	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	// a slice is held until the next hit or the end marker tells whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q    <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			if (valid_s2 && end_s2) begin
				result_strobe_q <= pend_valid_q;
				pend_valid_q    <= 1'b0;
			end else if (valid_s2 && hit_s2) begin
				result_strobe_q <= pend_valid_q;
				pend_valid_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && end_s2) begin
			result_q <= pend_last;
		end else if (valid_s2 && hit_s2) begin
			result_q <= pend_q;
			pend_q   <= rec;
		end
	end

	assign result        = result_q;
	assign result_strobe = result_strobe_q;

	a_slice_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe_q |-> (result_q.slice_length != '0))
		else $error("empty slice emitted");

	a_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && end_s2) |=> !pend_valid_q)
		else $error("held slice survives end of request");

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe_q |-> $past(valid_s2))
		else $error("result without walker step");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe_q && result_q.last) |-> !pend_valid_q)
		else $error("slice held after last slice");

endmodule
`default_nettype wire

>>> rtl/core/segment_range_splitter_core.sv
// An accepted split request passes the intake register and the queue before it reaches the
// walker; a slice is strobed through the stage 1, stage 2 and result registers after the
// walker step of the next hit or end step. The walker steps through the buffers in use (at
// most 16, one table entry per cycle) per split request; a 2-deep queue buffers requests.
// Results are strobed for one cycle. Reset clears control state and buffers_in_use;
// buffer lengths are undefined until written.
`default_nettype none
// ---------------------------------------------------------------------------
// segment_range_splitter_core: scatter/gather range splitter
// Splits a transfer request over back-to-back buffers of one segment.
// ---------------------------------------------------------------------------
module segment_range_splitter_core import srs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire item_t             item,
	output logic                   busy,
	output result_t                result,
	output logic                   result_strobe,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	logic [CNT_W-1:0] buffers_in_use_q;
	logic             reg_hit;
	logic             push;
	logic             pop;
	cmd_t             front_cmd;
	cmd_t             head_cmd;
	q_stat_t          q_stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1] == REG_BUFFERS_IN_USE);
	assign prdata  = reg_hit ? APB_DW'(buffers_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffers_in_use_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			buffers_in_use_q <= pwdata[CNT_W-1:0];
		end
	end

	srs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (front_cmd)
	);

	srs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.q_stat (q_stat)
	);

	srs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (head_cmd),
		.q_stat         (q_stat),
		.buffers_in_use (buffers_in_use_q),
		.pop            (pop),
		.result         (result),
		.result_strobe  (result_strobe)
	);

endmodule
`default_nettype wire

>>> bench/tb_segment_range_splitter_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_segment_range_splitter_core: self-checking bench for the range splitter
// Fills the buffer table, walks a table of directed requests, then runs
// random phases under different buffer counts. Every slice is checked
// field by field against a typed-in slice or a split over the table copy.
// ---------------------------------------------------------------------------
module tb_segment_range_splitter_core;
	import srs_pkg::*;

	localparam int          SETTLE_CYCLES   = 64;
	localparam int          MAX_GAP         = 12;
	localparam int          STRAY_REG_INDEX = 1;
	localparam int          PREDICTED       = -1;
	localparam int          PHASES          = 8;
	localparam int          PHASE_ITEMS     = 30;
	localparam logic [49:0] SUM_CAP         = 50'((64'd1 << SUM_W) - 1);

	typedef enum logic [1:0] {ROW_REQUEST, ROW_CONFIG, ROW_STRAY_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] value;
		item_t       req;
		int          typed;   // PREDICTED, or number of typed-in slices (0 or 1)
		result_t     slice;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	item_t                item = '0;
	logic                 busy;
	result_t              result;
	logic                 result_strobe;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	logic [OFFSET_BITS-1:0] buf_len_copy [MAX_BUFFERS];
	logic [4:0]             active_buffers = '0;
	result_t                pending_slices [$];
	stim_row_t              directed_rows [$];
	int                     mismatch_count = 0;

	segment_range_splitter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result(result),
		.result_strobe(result_strobe),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	function automatic void queue_slice(input result_t sl);
		pending_slices.insert(pending_slices.size(), sl);
	endfunction

	function automatic void add_row(input stim_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// split one request over the table copy, queue one slice per overlapped buffer
	function automatic void split_range(input item_t it);
		logic [49:0] seg_start, seg_end, cur, buf_end, lo, hi;
		int          n;
		logic        have_prev;
		result_t     prev, r;
		seg_start = 50'(it.req_offset);
		seg_end   = seg_start + 50'(it.request_length);
		n         = (active_buffers > MAX_BUFFERS) ? MAX_BUFFERS : int'(active_buffers);
		cur       = '0;
		have_prev = 1'b0;
		prev      = '0;
		for (int i = 0; i < n; i++) begin
			buf_end = cur + 50'(buf_len_copy[i]);
			if (buf_end > SUM_CAP)
				buf_end = SUM_CAP;
			lo = (seg_start > cur) ? seg_start : cur;
			hi = (seg_end < buf_end) ? seg_end : buf_end;
			if (lo < hi) begin
				r.buffer_index         = 4'(i);
				r.buf_offset           = OFFSET_BITS'(lo - cur);
				r.slice_length         = OFFSET_BITS'(hi - lo);
				r.slice_source_address = it.source_address + 64'(lo - seg_start);
				r.slice_opcode         = it.opcode;
				r.last                 = 1'b0;
				if (have_prev)
					queue_slice(prev);
				prev      = r;
				have_prev = 1'b1;
			end
			cur = buf_end;
		end
		if (have_prev) begin
			prev.last = 1'b1;
			queue_slice(prev);
		end
	endfunction

	function automatic void apply_request(input item_t it);
		if (it.action == ACT_WRITE)
			buf_len_copy[it.entry_index] = it.entry_length;
		else
			split_range(it);
	endfunction

	function automatic item_t make_item(input logic act, input logic [3:0] idx,
			input logic [47:0] elen, input logic [47:0] off, input logic [47:0] rlen,
			input logic [63:0] src, input logic op);
		item_t it;
		it.action         = act;
		it.entry_index    = idx;
		it.entry_length   = elen;
		it.req_offset     = off;
		it.request_length = rlen;
		it.source_address = src;
		it.opcode         = op;
		return it;
	endfunction

	function automatic result_t make_slice(input logic [3:0] idx, input logic [47:0] off,
			input logic [47:0] len, input logic [63:0] src, input logic op);
		result_t r;
		r.buffer_index         = idx;
		r.buf_offset           = off;
		r.slice_length         = len;
		r.slice_source_address = src;
		r.slice_opcode         = op;
		r.last                 = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t request_row(input item_t it, input int typed,
			input result_t sl);
		stim_row_t row;
		row.kind  = ROW_REQUEST;
		row.value = '0;
		row.req   = it;
		row.typed = typed;
		row.slice = sl;
		return row;
	endfunction

	function automatic stim_row_t register_row(input row_kind_t kind, input logic [31:0] v);
		stim_row_t row;
		row.kind  = kind;
		row.value = v;
		row.req   = '0;
		row.typed = 0;
		row.slice = '0;
		return row;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// mostly short buffers so requests cross several of them
	function automatic logic [47:0] rand_buf_len();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick < 4)
			return '0;
		else if (pick == 4)
			return rand48();
		else if (pick == 5)
			return '1;
		else
			return 48'($urandom_range(1, 64));
	endfunction

	function automatic item_t rand_request();
		item_t it;
		int    pick;
		it = make_item(1'($urandom), 4'($urandom), rand48(), rand48(), rand48(),
			{$urandom, $urandom}, 1'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			it.action       = ACT_WRITE;
			it.entry_length = rand_buf_len();
		end else begin
			it.action = ACT_SPLIT;
			if ($urandom_range(0, 4) != 0)
				it.req_offset = 48'($urandom_range(0, 700));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				it.request_length = '0;
			else if (pick != 1)
				it.request_length = 48'($urandom_range(1, 400));
		end
		return it;
	endfunction

	// called just after a rising edge; returns at the edge that takes the request
	task automatic push_request(input item_t it, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every slice is back, then let queued writes and empty splits finish
	task automatic drain_and_settle();
		start <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int reg_index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(reg_index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_buffers(input logic [31:0] value);
		drain_and_settle();
		apb_write(int'(REG_BUFFERS_IN_USE), value);
		active_buffers = value[4:0];
	endtask

	// slice checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_strobe) begin
			if (pending_slices.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected slice: idx=%0d off=%h len=%h src=%h op=%b last=%b",
						result.buffer_index, result.buf_offset, result.slice_length,
						result.slice_source_address, result.slice_opcode, result.last);
			end else begin
				want = pending_slices.pop_front();
				if (result.buffer_index !== want.buffer_index
						|| result.buf_offset !== want.buf_offset
						|| result.slice_length !== want.slice_length
						|| result.slice_source_address !== want.slice_source_address
						|| result.slice_opcode !== want.slice_opcode
						|| result.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("slice mismatch: got idx=%0d off=%h len=%h src=%h op=%b last=%b",
							result.buffer_index, result.buf_offset, result.slice_length,
							result.slice_source_address, result.slice_opcode, result.last);
						$display("                want idx=%0d off=%h len=%h src=%h op=%b last=%b",
							want.buffer_index, want.buf_offset, want.slice_length,
							want.slice_source_address, want.slice_opcode, want.last);
					end
				end
			end
		end
	end

	initial begin
		logic [47:0] len;
		int          gap;
		logic [31:0] phase_cfg [PHASES];
		item_t       it;

		foreach (buf_len_copy[i])
			buf_len_copy[i] = '0;

		// no buffers in use after reset: nothing to split
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, '0, 48'd100,
			'0, 1'b0), 0, '0));
		// 16 bytes, an empty buffer, three full-size buffers that saturate the sums, then 32s
		for (int i = 0; i < MAX_BUFFERS; i++) begin
			len = (i == 0) ? 48'd16 : (i == 1) ? 48'd0 : (i < 5) ? '1 : 48'd32;
			add_row(request_row(make_item(ACT_WRITE, 4'(i), len, '0, '0,
				'0, 1'b0), PREDICTED, '0));
		end
		// count above the table size clamps to the table size
		add_row(register_row(ROW_CONFIG, 32'd31));
		add_row(register_row(ROW_STRAY_REG, 32'd3));
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, '0, 48'd16,
			64'd0, 1'b1), 1, make_slice(4'd0, '0, 48'd16, 64'd0, 1'b1)));
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, 48'd4, 48'd8,
			'1, 1'b0), 1, make_slice(4'd0, 48'd4, 48'd8, '1, 1'b0)));
		// zero-length request
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, 48'd5, '0,
			64'd77, 1'b1), 0, '0));
		// starts right after the empty buffer
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, 48'd16, 48'd1,
			64'h1234, 1'b0), 1, make_slice(4'd2, '0, 48'd1, 64'h1234, 1'b0)));
		// source address wraps
		add_row(request_row(make_item(ACT_SPLIT, '1, '1, '0, '1,
			64'hFFFF_FFFF_FFFF_FFF8, 1'b1), PREDICTED, '0));
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, '1, '1,
			64'h0123_4567_89AB_CDEF, 1'b0), PREDICTED, '0));
		add_row(request_row(make_item(ACT_SPLIT, 4'd0, '0, 48'd10, 48'd100,
			{$urandom, $urandom}, 1'b1), PREDICTED, '0));

		phase_cfg = '{32'd16, 32'd0, 32'd1, 32'd31, 32'd7, 32'd16, 32'd12,
			32'($urandom_range(0, 31))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[r]) begin
			case (directed_rows[r].kind)
				ROW_CONFIG: begin
					set_buffers(directed_rows[r].value);
				end
				ROW_STRAY_REG: begin
					drain_and_settle();
					apb_write(STRAY_REG_INDEX, directed_rows[r].value);
				end
				default: begin
					push_request(directed_rows[r].req, $urandom_range(0, MAX_GAP));
					if (directed_rows[r].typed == PREDICTED
							|| directed_rows[r].req.action == ACT_WRITE)
						apply_request(directed_rows[r].req);
					else if (directed_rows[r].typed == 1)
						queue_slice(directed_rows[r].slice);
				end
			endcase
		end

		for (int p = 0; p < PHASES; p++) begin
			set_buffers(phase_cfg[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					while (pending_slices.size() != 0)
						@(posedge clk);
				end
				// every third phase runs back to back
				gap = (p % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
				it  = rand_request();
				push_request(it, gap);
				apply_request(it);
			end
		end

		start <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_slices.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> segment_range_splitter_core.f
rtl/core/srs_pkg.sv
rtl/core/srs_front.sv
rtl/core/srs_fifo.sv
rtl/core/srs_back.sv
rtl/core/segment_range_splitter_core.sv
bench/tb_segment_range_splitter_core.sv
